### rtl/quaternion_pose_to_matrix_assert.svh
// assertion macros for the quaternion pose to matrix block
// used by the top level only, expects clk and rst_n in scope
`ifndef QUATERNION_POSE_TO_MATRIX_ASSERT_SVH
`define QUATERNION_POSE_TO_MATRIX_ASSERT_SVH

// property that must hold at every edge outside reset
`define QP2M_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("qp2m assertion failed");

// property that must hold at the edge after a condition holds
`define QP2M_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("qp2m assertion failed");

`endif

### rtl/qp2m_pkg.sv
// shared constants and types for the quaternion pose to matrix block
// no dependencies
package qp2m_pkg;

    localparam int FRAC_BITS = 14;
    localparam int NLANE     = 9;                 // rotation entries
    localparam int QW        = FRAC_BITS + 2;     // quotient bits, one half-lsb extra
    localparam int NCELL     = QW;                // one divider cell per quotient bit
    localparam int NW        = 33;                // norm and magnitude width
    localparam int RW        = NW + 1;            // partial remainder width
    localparam int NUMW      = 35;                // signed numerator width
    localparam int PW        = 32;                // position width

    localparam logic [15:0] ONE_SAT = (FRAC_BITS >= 15) ? 16'h7fff : 16'(1 << FRAC_BITS);

    // lanes on the diagonal: elem_0, elem_5, elem_10
    localparam logic [NLANE-1:0] DIAG_MASK = 9'b100010001;

    typedef struct packed {
        logic [NLANE-1:0]           neg;
        logic [NLANE-1:0][RW-1:0]   rem;
        logic [NLANE-1:0][QW-1:0]   quo;
        logic [NW-1:0]              norm;
        logic                       zero;
        logic [2:0][PW-1:0]         pos;
    } div_t;

endpackage

### rtl/qp2m_front.sv
// front end: products, numerators, norm and magnitudes, three stages
// depends on qp2m_pkg
module qp2m_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [15:0] qx,
    input  logic signed [15:0] qy,
    input  logic signed [15:0] qz,
    input  logic signed [15:0] qw,
    input  logic [31:0]        px,
    input  logic [31:0]        py,
    input  logic [31:0]        pz,
    output logic               out_valid,
    output qp2m_pkg::div_t     out_data
);
    import qp2m_pkg::*;

    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [31:0]      xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0]      xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic [2:0][PW-1:0]      pos1_reg, pos2_reg;
    logic signed [NUMW-1:0]  num_reg [NLANE];
    logic signed [NUMW-1:0]  num_next [NLANE];
    logic [NW-1:0]           norm_reg, norm_next;
    div_t                    d3_reg, d3_next;
    logic signed [NUMW-1:0]  e_xx, e_yy, e_zz, e_ww, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
    logic [NUMW-1:0]         abs_v;

    // stage 2: numerators and norm
    always_comb
    begin
        e_xx = NUMW'(xx_reg);
        e_yy = NUMW'(yy_reg);
        e_zz = NUMW'(zz_reg);
        e_ww = NUMW'(ww_reg);
        e_xy = NUMW'(xy_reg);
        e_xz = NUMW'(xz_reg);
        e_yz = NUMW'(yz_reg);
        e_wx = NUMW'(wx_reg);
        e_wy = NUMW'(wy_reg);
        e_wz = NUMW'(wz_reg);
        norm_next   = NW'(e_xx + e_yy + e_zz + e_ww);
        num_next[0] = e_xx + e_ww - e_yy - e_zz;
        num_next[1] = (e_xy - e_wz) <<< 1;
        num_next[2] = (e_xz + e_wy) <<< 1;
        num_next[3] = (e_xy + e_wz) <<< 1;
        num_next[4] = e_yy + e_ww - e_xx - e_zz;
        num_next[5] = (e_yz - e_wx) <<< 1;
        num_next[6] = (e_xz - e_wy) <<< 1;
        num_next[7] = (e_yz + e_wx) <<< 1;
        num_next[8] = e_zz + e_ww - e_xx - e_yy;
    end

    // stage 3: sign and magnitude
    always_comb
    begin
        abs_v = '0;
        d3_next.norm = norm_reg;
        d3_next.zero = (norm_reg == '0);
        d3_next.pos  = pos2_reg;
        for (int i = 0; i < NLANE; i++)
        begin
            d3_next.neg[i] = num_reg[i][NUMW-1];
            abs_v = num_reg[i][NUMW-1] ? NUMW'(-num_reg[i]) : NUMW'(num_reg[i]);
            d3_next.rem[i] = {1'b0, abs_v[NW-1:0]};
            d3_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg   <= qx * qx;
            yy_reg   <= qy * qy;
            zz_reg   <= qz * qz;
            ww_reg   <= qw * qw;
            xy_reg   <= qx * qy;
            xz_reg   <= qx * qz;
            yz_reg   <= qy * qz;
            wx_reg   <= qw * qx;
            wy_reg   <= qw * qy;
            wz_reg   <= qw * qz;
            pos1_reg <= {pz, py, px};
            num_reg  <= num_next;
            norm_reg <= norm_next;
            pos2_reg <= pos1_reg;
            d3_reg   <= d3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

### rtl/qp2m_div_cell.sv
// one divider cell: one quotient bit for every lane, then hand on
// depends on qp2m_pkg
module qp2m_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  qp2m_pkg::div_t in_data,
    output logic           out_valid,
    output qp2m_pkg::div_t out_data
);
    import qp2m_pkg::*;

    logic          valid_reg;
    div_t          data_reg, data_next;
    logic          qbit;
    logic [RW-1:0] diff;

    always_comb
    begin
        qbit = 1'b0;
        diff = '0;
        data_next = in_data;
        for (int i = 0; i < NLANE; i++)
        begin
            qbit = (in_data.rem[i] >= {1'b0, in_data.norm});
            diff = qbit ? (in_data.rem[i] - {1'b0, in_data.norm}) : in_data.rem[i];
            data_next.rem[i] = {diff[RW-2:0], 1'b0};
            data_next.quo[i] = {in_data.quo[i][QW-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/quaternion_pose_to_matrix.sv
// quaternion and position to 4x4 transform: nine rotation entries plus translation
// top level; uses qp2m_pkg, qp2m_front, qp2m_div_cell and the assertion header
//
// usage:
//   input channel in_valid / in_ready carries one pose per beat: quaternion
//   quat_x..quat_w in Q2.14 and position pos_x..pos_z in Q16.16
//   output channel out_valid / out_ready carries the matrix: elem_0..elem_10
//   (rotation, Q2.14, rounded to nearest, ties away from zero, saturated)
//   and elem_12..elem_14 (position passed through)
//   rotation uses s = 2 / |q|^2, so non-unit quaternions still give a rotation;
//   a zero quaternion gives the identity rotation
// pipeline: 3 front stages, 16 divider cells and one output register
// throughput: one beat per cycle unless the pipeline stalls; the divider is a chain of cells, each
//   producing one quotient bit for all nine entries and passing on
// stall: the whole pipeline holds while the output register is full and
//   out_ready is low; in_ready falls in the same cycle
// reset: rst_n clears all valid flags; no item is in flight afterward
module quaternion_pose_to_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] elem_0,
    output logic signed [15:0] elem_1,
    output logic signed [15:0] elem_2,
    output logic signed [15:0] elem_4,
    output logic signed [15:0] elem_5,
    output logic signed [15:0] elem_6,
    output logic signed [15:0] elem_8,
    output logic signed [15:0] elem_9,
    output logic signed [15:0] elem_10,
    output logic signed [31:0] elem_12,
    output logic signed [31:0] elem_13,
    output logic signed [31:0] elem_14
);
    import qp2m_pkg::*;

    logic                   en;
    logic [NCELL:0]         cv;          // valid flag of each chain stage
    div_t                   cd [NCELL+1];
    logic                   out_valid_reg;
    logic [15:0]            elem_reg [NLANE];
    logic [15:0]            elem_next [NLANE];
    logic [2:0][PW-1:0]     pos_reg;
    logic [QW:0]            rsum;
    logic [QW+15:0]         qx_w;
    div_t                   fin;

    // whole pipeline moves when the output register can take a beat
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    qp2m_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .qx        (quat_x),
        .qy        (quat_y),
        .qz        (quat_z),
        .qw        (quat_w),
        .px        (pos_x),
        .py        (pos_y),
        .pz        (pos_z),
        .out_valid (cv[0]),
        .out_data  (cd[0])
    );

    // divider chain, msb of the quotient first
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        qp2m_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cv[k]),
            .in_data   (cd[k]),
            .out_valid (cv[k+1]),
            .out_data  (cd[k+1])
        );
    end

    assign fin = cd[NCELL];

    // quotient holds twice the ratio; add the half and drop it, then
    // saturate, apply the sign and handle the zero quaternion
    always_comb
    begin
        rsum = '0;
        qx_w = '0;
        for (int i = 0; i < NLANE; i++)
        begin
            rsum = {1'b0, fin.quo[i]} + (QW+1)'(1);
            qx_w = (QW+16)'(rsum[QW:1]);
            if (fin.zero)
                elem_next[i] = DIAG_MASK[i] ? ONE_SAT : 16'h0000;
            else if (fin.neg[i])
                elem_next[i] = (qx_w >= (QW+16)'(32768)) ? 16'h8000 : 16'(-qx_w[15:0]);
            else
                elem_next[i] = (qx_w > (QW+16)'(32767)) ? 16'h7fff : qx_w[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= cv[NCELL];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            elem_reg <= elem_next;
            pos_reg  <= fin.pos;
        end
    end

    assign out_valid = out_valid_reg;
    assign elem_0    = elem_reg[0];
    assign elem_1    = elem_reg[1];
    assign elem_2    = elem_reg[2];
    assign elem_4    = elem_reg[3];
    assign elem_5    = elem_reg[4];
    assign elem_6    = elem_reg[5];
    assign elem_8    = elem_reg[6];
    assign elem_9    = elem_reg[7];
    assign elem_10   = elem_reg[8];
    assign elem_12   = pos_reg[0];
    assign elem_13   = pos_reg[1];
    assign elem_14   = pos_reg[2];

`include "quaternion_pose_to_matrix_assert.svh"

    // a stalled pipeline keeps every beat in its stage
    `QP2M_ASSERT_NEXT(a_stall_holds, !en, $stable(cv))
    // lane 0 remainder leaving the chain stays below twice the norm
    `QP2M_ASSERT(a_rem_bound, !cv[NCELL] || fin.zero || (fin.rem[0] < {fin.norm, 1'b0}))
    // a beat in the last cell reaches the output register when the chain moves
    `QP2M_ASSERT_NEXT(a_out_load, en && cv[NCELL], out_valid)

endmodule

### tb/qp2m_matrix_checker.sv
// checker for the quaternion pose to matrix block: predicts each matrix and compares
// depends on qp2m_pkg for FRAC_BITS
module qp2m_matrix_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] elem_0,
    input  logic signed [15:0] elem_1,
    input  logic signed [15:0] elem_2,
    input  logic signed [15:0] elem_4,
    input  logic signed [15:0] elem_5,
    input  logic signed [15:0] elem_6,
    input  logic signed [15:0] elem_8,
    input  logic signed [15:0] elem_9,
    input  logic signed [15:0] elem_10,
    input  logic signed [31:0] elem_12,
    input  logic signed [31:0] elem_13,
    input  logic signed [31:0] elem_14,
    output int                 fail_count,
    output int                 pending
);
    import qp2m_pkg::FRAC_BITS;

    typedef struct packed {
        logic signed [8:0][15:0] rot;
        logic signed [2:0][31:0] pos;
    } matrix_t;

    matrix_t expected_matrices[$];
    int      beat_idx;

    // rounded ratio num * 2^FRAC_BITS / n, ties away from zero, saturated to 16 bits
    function automatic logic signed [15:0] rot_entry(longint num, longint n, bit diag);
        longint mag;
        longint q;
        if (n == 0)
            q = diag ? (longint'(1) << FRAC_BITS) : 0;
        else
        begin
            mag = (num < 0) ? -num : num;
            mag = mag << FRAC_BITS;
            q = (2 * mag + n) / (2 * n);
            if (num < 0)
                q = -q;
        end
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    function automatic matrix_t pose_to_matrix(longint x, longint y, longint z, longint w,
                                               logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz);
        matrix_t m;
        longint  n;
        n = x*x + y*y + z*z + w*w;
        m.rot[0] = rot_entry(n - 2*(y*y + z*z), n, 1);
        m.rot[1] = rot_entry(2*(x*y - w*z), n, 0);
        m.rot[2] = rot_entry(2*(x*z + w*y), n, 0);
        m.rot[3] = rot_entry(2*(x*y + w*z), n, 0);
        m.rot[4] = rot_entry(n - 2*(x*x + z*z), n, 1);
        m.rot[5] = rot_entry(2*(y*z - w*x), n, 0);
        m.rot[6] = rot_entry(2*(x*z - w*y), n, 0);
        m.rot[7] = rot_entry(2*(y*z + w*x), n, 0);
        m.rot[8] = rot_entry(n - 2*(x*x + y*y), n, 1);
        m.pos[0] = px;
        m.pos[1] = py;
        m.pos[2] = pz;
        return m;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch beat %0d %s: got %0d want %0d", beat_idx, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
        beat_idx   = 0;
    end

    always @(posedge clk)
    begin
        matrix_t got;
        matrix_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_matrices.push_back(pose_to_matrix(quat_x, quat_y, quat_z, quat_w,
                                                           pos_x, pos_y, pos_z));
            if (out_valid && out_ready)
            begin
                got.rot = {elem_10, elem_9, elem_8, elem_6, elem_5, elem_4,
                           elem_2, elem_1, elem_0};
                got.pos = {elem_14, elem_13, elem_12};
                if (expected_matrices.size() == 0)
                begin
                    $display("unexpected output beat %0d", beat_idx);
                    fail_count++;
                end
                else
                begin
                    want = expected_matrices.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got.rot[i] !== want.rot[i])
                            report_mismatch($sformatf("rot[%0d]", i), got.rot[i], want.rot[i]);
                    for (int i = 0; i < 3; i++)
                        if (got.pos[i] !== want.pos[i])
                            report_mismatch($sformatf("pos[%0d]", i), got.pos[i], want.pos[i]);
                end
                beat_idx++;
            end
            pending <= expected_matrices.size();
        end
    end
endmodule

### tb/tb_quaternion_pose_to_matrix.sv
// testbench top for quaternion_pose_to_matrix: stimulus, stalls and verdict
// depends on the block rtl and tb/qp2m_matrix_checker.sv
module tb_quaternion_pose_to_matrix;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] elem_0, elem_1, elem_2, elem_4, elem_5, elem_6;
    logic signed [15:0] elem_8, elem_9, elem_10;
    logic signed [31:0] elem_12, elem_13, elem_14;
    int                 fail_count;
    int                 pending;
    bit                 stim_done;

    localparam int RANDOM_POSES = 1700;
    localparam int DRAIN_CYCLES = 40;   // longer than the pipeline

    quaternion_pose_to_matrix u_top (.*);

    qp2m_matrix_checker u_checker (.*);

    // 20 unit period clock
    initial clk = 0;
    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // one pose beat: wait a random gap unless no_gap is set, present it, hold until accepted
    task automatic send_pose(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                             logic [15:0] qw, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        repeat (gap)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        quat_x <= qx;
        quat_y <= qy;
        quat_z <= qz;
        quat_w <= qw;
        pos_x  <= px;
        pos_y  <= py;
        pos_z  <= pz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // quaternion component: mostly moderate values, sometimes extremes or zero
    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // output side: random stall per beat, with stretches of none
    initial
    begin
        int stall;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (($time / 20000) % 3 == 1)
                stall = 0;
            if (stall == 0)
                out_ready <= 1;
            else
            begin
                out_ready <= 0;
                repeat (stall) @(negedge clk);
                out_ready <= 1;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        bit burst;
        in_valid  = 0;
        quat_x    = 0;
        quat_y    = 0;
        quat_z    = 0;
        quat_w    = 0;
        pos_x     = 0;
        pos_y     = 0;
        pos_z     = 0;
        stim_done = 0;
        rst_n     = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: identity, zero quaternion, single axes, extremes, non-unit
        send_pose(16'h0000, 16'h0000, 16'h0000, 16'h4000, 32'h0, 32'h0, 32'h0, 0);
        send_pose(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h7fffffff, 32'h80000000,
                  32'hffffffff, 0);
        send_pose(16'h4000, 16'h0000, 16'h0000, 16'h0000, 32'h1, 32'h2, 32'h3, 0);
        send_pose(16'h0000, 16'h4000, 16'h0000, 16'h0000, 32'h80000000, 32'h0, 32'h7fffffff, 1);
        send_pose(16'h0000, 16'h0000, 16'h4000, 16'h0000, 32'h0, 32'h0, 32'h0, 1);
        send_pose(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'haaaaaaaa, 32'h55555555,
                  32'h0, 0);
        send_pose(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'h55555555, 32'haaaaaaaa,
                  32'hffffffff, 0);
        send_pose(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 32'h0, 32'h0, 32'h0, 1);
        send_pose(16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 0);
        send_pose(16'h0000, 16'h0000, 16'h0000, 16'hffff, 32'h0, 32'h0, 32'h0, 0);
        send_pose(16'h0001, 16'h0001, 16'h0001, 16'h0001, 32'h0, 32'h0, 32'h0, 1);
        send_pose(16'h2d41, 16'h0000, 16'h0000, 16'h2d41, 32'h0, 32'h0, 32'h0, 0);
        send_pose(16'h0003, 16'hfffe, 16'h0001, 16'h0000, 32'h0, 32'h0, 32'h0, 0);
        send_pose(16'h0000, 16'h0000, 16'h0000, 16'h0100, 32'h0, 32'h0, 32'h0, 0);

        // random: bursts with no gaps mixed with gapped stretches
        for (int i = 0; i < RANDOM_POSES; i++)
        begin
            if (i % 100 == 0)
                burst = $urandom_range(0, 2) == 0;
            send_pose(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                      $urandom, $urandom, $urandom, burst);
        end
        in_valid  <= 0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
